FILE: design/gda_pkg.sv
`timescale 1ns / 1ps

package gda_pkg;

    // Operation codes
    localparam logic [2:0] OP_ADD_YEARS    = 3'd0;
    localparam logic [2:0] OP_ADD_MONTHS   = 3'd1;
    localparam logic [2:0] OP_ADD_DAYS     = 3'd2;
    localparam logic [2:0] OP_DAYS_BETWEEN = 3'd3;
    localparam logic [2:0] OP_COMPARE      = 3'd4;

    // Order codes
    localparam logic [1:0] ORD_LESS    = 2'd0;
    localparam logic [1:0] ORD_EQUAL   = 2'd1;
    localparam logic [1:0] ORD_GREATER = 2'd2;

    // Calendar constants
    localparam int YEAR_MIN   = 1;
    localparam int YEAR_MAX   = 9999;
    localparam int EPOCH_YEAR = 4800;
    localparam int JDN_BIAS   = 32045;
    localparam int CIV_BIAS   = 32044;
    localparam int JDN_FIRST  = 1721426;
    localparam int JDN_LAST   = 5373484;
    localparam int DIFF_MAX   = 4194303;
    localparam int DIFF_MIN   = -4194304;
    localparam longint unsigned DAYS_400Y = 64'd146097;
    localparam longint unsigned DAYS_4Y   = 64'd1461;

    // Reciprocal constants: K = ceil(2^S / D), exact while x * D < 2^S
    localparam int DIV100_S = 22;
    localparam longint unsigned DIV100_K = ((64'd1 << DIV100_S) + 64'd99) / 64'd100;
    localparam int LEAP_S = 21;
    localparam longint unsigned LEAP_K = ((64'd1 << LEAP_S) + 64'd99) / 64'd100;
    localparam int DIV12_S = 27;
    localparam longint unsigned DIV12_K = ((64'd1 << DIV12_S) + 64'd11) / 64'd12;
    localparam int DIVB_S = 43;
    localparam longint unsigned DIVB_K =
        ((64'd1 << DIVB_S) + DAYS_400Y - 64'd1) / DAYS_400Y;
    localparam int DIVE4_S = 29;
    localparam longint unsigned DIVE4_K =
        ((64'd1 << DIVE4_S) + DAYS_4Y - 64'd1) / DAYS_4Y;
    localparam int DIVMM_S = 19;
    localparam longint unsigned DIVMM_K = ((64'd1 << DIVMM_S) + 64'd152) / 64'd153;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } date_t;

    // Days before month, March-based month index: (153 * mm + 2) / 5
    function automatic logic [8:0] month_offset(input logic [3:0] mm);
        logic [8:0] r;
        case (mm)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            4'd12:   r = 9'd367;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // Month length, non-leap February
    function automatic logic [4:0] month_days(input logic [3:0] m);
        logic [4:0] r;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
            4'd2:                                       r = 5'd28;
            default:                                    r = 5'd0;
        endcase
        return r;
    endfunction

    // Gregorian leap test; low product bits below K mark a multiple of 100
    function automatic logic is_leap(input logic [13:0] y);
        logic [28:0] p;
        logic        cent;
        p    = 29'(y) * 29'(LEAP_K);
        cent = p[20:0] < 21'(LEAP_K);
        return (y[1:0] == 2'b00) && (!cent || (p[22:21] == 2'b00));
    endfunction

endpackage

FILE: design/gda_jdn.sv
`timescale 1ns / 1ps

// Date to Julian Day Number, two register stages
module gda_jdn (
    input  logic                aclk,
    input  logic                en,
    input  gda_pkg::date_t      date_i,
    output logic [22:0]         jdn_o
);

    logic        early;
    logic [14:0] yy;
    logic [3:0]  mm;
    logic [29:0] p100;

    logic [14:0] yy_reg;
    logic [7:0]  q100_reg;
    logic [9:0]  dt_reg;
    logic [23:0] sum_next;
    logic [22:0] jdn_reg;

    // Stage 1: shifted year, century count, day plus month offset
    always_comb begin
        early = date_i.month < 4'd3;
        yy    = 15'(date_i.year) + 15'(gda_pkg::EPOCH_YEAR) - 15'(early);
        mm    = early ? date_i.month + 4'd9 : date_i.month - 4'd3;
        p100  = 30'(yy) * 30'(gda_pkg::DIV100_K);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            yy_reg   <= yy;
            q100_reg <= p100[29:22];
            dt_reg   <= 10'(date_i.day) + 10'(gda_pkg::month_offset(mm));
        end
    end

    // Stage 2: day count sum
    always_comb begin
        sum_next = 24'(dt_reg) + 24'(yy_reg) * 24'd365 + 24'(yy_reg >> 2)
                 - 24'(q100_reg) + 24'(q100_reg >> 2) - 24'(gda_pkg::JDN_BIAS);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            jdn_reg <= sum_next[22:0];
        end
    end

    assign jdn_o = jdn_reg;

endmodule

FILE: design/gda_civil.sv
`timescale 1ns / 1ps

// Julian Day Number to date, six register stages, constant multiplies in each stage
module gda_civil (
    input  logic                aclk,
    input  logic                en,
    input  logic [22:0]         jdn_i,
    output gda_pkg::date_t      date_o
);

    logic [22:0] a_in;
    logic [50:0] pb;
    logic [24:0] pc;
    logic [36:0] pe;
    logic [17:0] pd;
    logic [10:0] xm;
    logic [22:0] pm;

    logic [22:0] a1_reg;
    logic [7:0]  b1_reg, b2_reg, b3_reg, b4_reg, b5_reg;
    logic [15:0] c2_reg, c3_reg;
    logic [6:0]  e43_reg, e44_reg, e45_reg;
    logic [8:0]  e4_reg, e5_reg;
    logic [3:0]  mm5_reg;
    logic        wrap;
    logic [8:0]  day_w;
    logic [14:0] year_w;
    gda_pkg::date_t date_reg;

    // Stage 1: century index
    always_comb begin
        a_in = jdn_i + 23'(gda_pkg::CIV_BIAS);
        pb   = 51'({a_in, 2'b11}) * 51'(gda_pkg::DIVB_K);
    end

    // Stage 2: day within the century
    always_comb begin
        pc = 25'(b1_reg) * 25'(gda_pkg::DAYS_400Y);
    end

    // Stage 3: year within the century
    always_comb begin
        pe = 37'({c2_reg, 2'b11}) * 37'(gda_pkg::DIVE4_K);
    end

    // Stage 4: day within the year (March based)
    always_comb begin
        pd = 18'(e43_reg) * 18'(gda_pkg::DAYS_4Y);
    end

    // Stage 5: month index
    always_comb begin
        xm = 11'(e4_reg) * 11'd5 + 11'd2;
        pm = 23'(xm) * 23'(gda_pkg::DIVMM_K);
    end

    // Stage 6: assemble the date
    always_comb begin
        wrap   = mm5_reg >= 4'd10;
        day_w  = e5_reg - gda_pkg::month_offset(mm5_reg) + 9'd1;
        year_w = 15'(b5_reg) * 15'd100 + 15'(e45_reg) + 15'(wrap)
               - 15'(gda_pkg::EPOCH_YEAR);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a1_reg   <= a_in;
            b1_reg   <= pb[50:43];
            b2_reg   <= b1_reg;
            c2_reg   <= 16'(a1_reg - 23'(pc >> 2));
            b3_reg   <= b2_reg;
            c3_reg   <= c2_reg;
            e43_reg  <= pe[35:29];
            b4_reg   <= b3_reg;
            e44_reg  <= e43_reg;
            e4_reg   <= 9'(c3_reg - 16'(pd >> 2));
            b5_reg   <= b4_reg;
            e45_reg  <= e44_reg;
            e5_reg   <= e4_reg;
            mm5_reg  <= pm[22:19];
            date_reg.year  <= year_w[13:0];
            date_reg.month <= wrap ? mm5_reg - 4'd9 : mm5_reg + 4'd3;
            date_reg.day   <= day_w[4:0];
        end
    end

    assign date_o = date_reg;

endmodule

FILE: design/gregorian_date_arithmetic_unit.sv
`timescale 1ns / 1ps

// Channel  Ports                          Fields
// input    s_tvalid s_tready s_tdata      tdata: year month day amount
//          s_tuser                        other_year other_month other_day
//                                         tuser: opcode
// result   m_tvalid m_tready m_tdata      tdata: result_year result_month
//                                         result_day day_difference order
//                                         range_error
//
// One item per cycle while the output register is empty or taken; each item passes
// through the nine pipeline stages (two for the date to day-number conversion,
// one for day arithmetic, six for the day-number to date conversion) and then
// the output register. Reset clears the stage valid bits and the output valid.
// The whole pipeline advances when the output register is empty or taken;
// s_tready is low only while a result is held.
module gregorian_date_arithmetic_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [13:0] year, [17:14] month, [22:18] day, [45:23] amount,
    // [59:46] other_year, [63:60] other_month, [68:64] other_day
    input  logic [71:0] s_tdata,
    // [2:0] opcode
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [13:0] result_year, [17:14] result_month, [22:18] result_day,
    // [45:23] day_difference, [47:46] order, [48] range_error
    output logic [55:0] m_tdata
);

    typedef struct packed {
        gda_pkg::date_t     date;
        logic signed [22:0] diff;
        logic [1:0]         ord;
        logic               err;
    } res_t;

    typedef struct packed {
        logic civ;
        res_t res;
    } stage_t;

    localparam res_t RES_NONE = '0;
    localparam res_t RES_ERR  = '{date: '0, diff: '0, ord: '0, err: 1'b1};

    logic en;
    logic [9:1] vld_reg;
    logic       out_vld_reg;
    res_t       out_reg;

    // Input unpacking
    gda_pkg::date_t     date1, date2;
    logic signed [22:0] amt;
    logic [2:0]         op;

    assign op          = s_tuser;
    assign date1.year  = s_tdata[13:0];
    assign date1.month = s_tdata[17:14];
    assign date1.day   = s_tdata[22:18];
    assign amt         = s_tdata[45:23];
    assign date2.year  = s_tdata[59:46];
    assign date2.month = s_tdata[63:60];
    assign date2.day   = s_tdata[68:64];

    assign en       = !out_vld_reg || m_tready;
    assign s_tready = en;

    // Valid bits travel with the stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[8:1], s_tvalid};
            out_vld_reg <= vld_reg[9];
        end
    end

    // Day numbers of both dates, ready at stage 2
    logic [22:0] jdn1, jdn2;

    gda_jdn u_jdn1 (.aclk(aclk), .en(en), .date_i(date1), .jdn_o(jdn1));
    gda_jdn u_jdn2 (.aclk(aclk), .en(en), .date_i(date2), .jdn_o(jdn2));

    // Stage 1: year sum, month count, order
    logic [2:0]         op1_reg;
    logic signed [22:0] amt1_reg;
    logic [3:0]         m1_reg;
    logic [4:0]         d1_reg;
    logic signed [23:0] ry0_reg;
    logic signed [24:0] tot_reg;
    logic [1:0]         ord1_reg;
    logic [22:0]        key1, key2;
    logic [1:0]         ord_next;

    always_comb begin
        key1 = {date1.year, date1.month, date1.day};
        key2 = {date2.year, date2.month, date2.day};
        if (key1 < key2) begin
            ord_next = gda_pkg::ORD_LESS;
        end else if (key1 == key2) begin
            ord_next = gda_pkg::ORD_EQUAL;
        end else begin
            ord_next = gda_pkg::ORD_GREATER;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op1_reg  <= op;
            amt1_reg <= amt;
            m1_reg   <= date1.month;
            d1_reg   <= date1.day;
            ry0_reg  <= 24'(date1.year) + 24'(amt);
            tot_reg  <= 25'(date1.year) * 25'd12 + 25'(date1.month) - 25'd1 + 25'(amt);
            ord1_reg <= ord_next;
        end
    end

    // Stage 2: year add finished, month count split by 12
    logic               ok0, lp0;
    logic [4:0]         rd0;
    res_t               res0;
    logic [46:0]        p12;
    logic [2:0]         op2_reg;
    logic signed [22:0] amt2_reg;
    res_t               res0_reg;
    logic               neg2_reg;
    logic [22:0]        tu2_reg;
    logic [18:0]        q12_reg;
    logic [4:0]         d2_reg;
    logic [1:0]         ord2_reg;

    always_comb begin
        ok0 = (ry0_reg >= 24'sd1) && (ry0_reg <= 24'sd9999);
        lp0 = gda_pkg::is_leap(ry0_reg[13:0]);
        rd0 = (m1_reg == 4'd2 && d1_reg == 5'd29 && !lp0) ? 5'd28 : d1_reg;
        res0 = RES_NONE;
        if (ok0) begin
            res0.date.year  = ry0_reg[13:0];
            res0.date.month = m1_reg;
            res0.date.day   = rd0;
        end else begin
            res0 = RES_ERR;
        end
        p12 = 47'(tot_reg[22:0]) * 47'(gda_pkg::DIV12_K);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op2_reg  <= op1_reg;
            amt2_reg <= amt1_reg;
            res0_reg <= res0;
            neg2_reg <= tot_reg[24];
            tu2_reg  <= tot_reg[22:0];
            q12_reg  <= p12[45:27];
            d2_reg   <= d1_reg;
            ord2_reg <= ord1_reg;
        end
    end

    // Stage 3: month add finished, day add, day difference, result select
    logic [22:0]        rem12;
    logic [3:0]         rm1;
    logic               ok1, lp1;
    logic [4:0]         maxd, rd1;
    logic signed [24:0] j_s;
    logic               jerr;
    logic signed [23:0] diff_s;
    logic signed [22:0] diff_sat;
    stage_t             st3;
    logic [22:0]        j3_reg;
    stage_t             stg_reg [3:9];

    always_comb begin
        rem12 = tu2_reg - 23'(q12_reg) * 23'd12;
        rm1   = rem12[3:0] + 4'd1;
        ok1   = !neg2_reg && (q12_reg >= 19'd1) && (q12_reg <= 19'd9999);
        lp1   = gda_pkg::is_leap(q12_reg[13:0]);
        maxd  = (rm1 == 4'd2 && lp1) ? 5'd29 : gda_pkg::month_days(rm1);
        rd1   = (d2_reg > maxd) ? maxd : d2_reg;

        j_s  = $signed({2'b00, jdn1}) + 25'(amt2_reg);
        jerr = (j_s < 25'sd1721426) || (j_s > 25'sd5373484);

        diff_s = $signed({1'b0, jdn2}) - $signed({1'b0, jdn1});
        if (diff_s > 24'sd4194303) begin
            diff_sat = 23'sh3FFFFF;
        end else if (diff_s < -24'sd4194304) begin
            diff_sat = 23'sh400000;
        end else begin
            diff_sat = 23'(diff_s);
        end

        st3.civ = 1'b0;
        st3.res = RES_NONE;
        case (op2_reg)
            gda_pkg::OP_ADD_YEARS: begin
                st3.res = res0_reg;
            end
            gda_pkg::OP_ADD_MONTHS: begin
                if (ok1) begin
                    st3.res.date.year  = q12_reg[13:0];
                    st3.res.date.month = rm1;
                    st3.res.date.day   = rd1;
                end else begin
                    st3.res = RES_ERR;
                end
            end
            gda_pkg::OP_ADD_DAYS: begin
                if (jerr) begin
                    st3.res = RES_ERR;
                end else begin
                    st3.civ = 1'b1;
                end
            end
            gda_pkg::OP_DAYS_BETWEEN: begin
                st3.res.diff = diff_sat;
            end
            gda_pkg::OP_COMPARE: begin
                st3.res.ord = ord2_reg;
            end
            default: begin
                st3.res = RES_NONE;
            end
        endcase
    end

    // Stages 3 to 9: select and early results wait for the date conversion
    always_ff @(posedge aclk) begin
        if (en) begin
            j3_reg     <= j_s[22:0];
            stg_reg[3] <= st3;
            for (int k = 4; k <= 9; k++) begin
                stg_reg[k] <= stg_reg[k-1];
            end
        end
    end

    gda_pkg::date_t civ_date;

    gda_civil u_civil (.aclk(aclk), .en(en), .jdn_i(j3_reg), .date_o(civ_date));

    // Output register
    res_t out_next;

    always_comb begin
        out_next = stg_reg[9].res;
        if (stg_reg[9].civ) begin
            out_next      = RES_NONE;
            out_next.date = civ_date;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {7'd0, out_reg.err, out_reg.ord, out_reg.diff,
                       out_reg.date.day, out_reg.date.month, out_reg.date.year};

    // A converted day number always lands on a real date in range
    a_civ_date_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[9] && stg_reg[9].civ |->
            civ_date.month >= 4'd1 && civ_date.month <= 4'd12 &&
            civ_date.day >= 5'd1 && civ_date.day <= 5'd31 &&
            civ_date.year >= 14'd1 && civ_date.year <= 14'd9999)
        else $error("day-number conversion gave an invalid date");

    // Range error clears the date fields
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[48] |-> m_tdata[22:0] == 23'd0)
        else $error("range error with nonzero date");

    // A nonzero order comes only from a compare and carries nothing else
    a_ord_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[47:46] != gda_pkg::ORD_LESS |->
            m_tdata[45:0] == 46'd0 && !m_tdata[48])
        else $error("order set together with other result fields");

    // Output valid only rises from the last pipeline stage
    a_out_from_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_vld_reg) |-> $past(vld_reg[9]))
        else $error("output valid without a finished item");

endmodule
